### src/edm_pkg.sv
// ----------------------------------------------------------------------------
// edm_pkg: shared types and constants
// Register indexes, field widths and controller states for the mean
// epipolar distance block.
// ----------------------------------------------------------------------------
package edm_pkg;

	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int COORD_FRAC  = 4;
	localparam int DIST_W      = 20;
	localparam int SUM_W       = 48;
	localparam int CAP_LOG     = 58;  // |N| is capped at 2^CAP_LOG
	localparam int M_W         = 63;  // 16 * capped |N|
	localparam int SQ_W        = 127; // squares and root trial values
	localparam int S_W         = 64;  // l0^2 + l1^2
	localparam int LMAG_W      = 32;  // |l0|, |l1| after normalization (up to 2^31)
	localparam int STEP_W      = 6;

	localparam int DEF_COORD_W = 16;
	localparam int DEF_COEF_W  = 32;
	localparam int DEF_COUNT_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAIR_A = 3'd0,
		CFG_PAIR_B = 3'd1,
		CFG_PAIR_C = 3'd2,
		CFG_PAIR_D = 3'd3,
		CFG_CORNER = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LINE,
		ST_NORM,
		ST_DOT,
		ST_LAUNCH,
		ST_WAIT,
		ST_ACC,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		RT_IDLE,
		RT_SQR,
		RT_ROOT,
		RT_DONE
	} root_state_t;

endpackage

### src/edm_root.sv
// ----------------------------------------------------------------------------
// edm_root: bit-serial distance unit
// Squares S = a0^2 + a1^2 and M^2 by shift-add, then finds the largest
// q < 2^20 with q^2 * S <= M^2, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module edm_root (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [edm_pkg::LMAG_W-1:0]          a0,
	input  logic [edm_pkg::LMAG_W-1:0]          a1,
	input  logic [edm_pkg::M_W-1:0]             m,
	output logic                                done,
	output logic [edm_pkg::DIST_W-1:0]          q
);

	edm_pkg::root_state_t rt_q, rt_d;
	logic [edm_pkg::STEP_W-1:0] step_q;
	logic [edm_pkg::LMAG_W-1:0] a0_q, a1_q;
	logic [edm_pkg::M_W-1:0]    m_q, sh0_q, sh1_q, shm_q;
	logic [edm_pkg::S_W-1:0]    s_q, s_next;
	logic [edm_pkg::SQ_W-1:0]   msq_q, msq_next;
	logic [edm_pkg::SQ_W-1:0]   p_q, ts_q, ss_q, cand;
	logic [edm_pkg::DIST_W-1:0] q_q;
	logic                       take;

	always_comb begin
		s_next = (s_q << 1)
			+ (sh0_q[edm_pkg::M_W-1] ? edm_pkg::S_W'(a0_q) : '0)
			+ (sh1_q[edm_pkg::M_W-1] ? edm_pkg::S_W'(a1_q) : '0);
		msq_next = (msq_q << 1) + (shm_q[edm_pkg::M_W-1] ? edm_pkg::SQ_W'(m_q) : '0);
		// trial (q | 2^b)^2 * S = P + (T << (b+1)) + (S << 2b)
		cand = p_q + ts_q + ss_q;
		take = (cand <= msq_q);
	end

	always_comb begin
		rt_d = rt_q;
		unique case (rt_q)
			edm_pkg::RT_IDLE: begin
				if (start) rt_d = edm_pkg::RT_SQR;
			end
			edm_pkg::RT_SQR: begin
				if (step_q == '0) rt_d = edm_pkg::RT_ROOT;
			end
			edm_pkg::RT_ROOT: begin
				if (step_q == '0) rt_d = edm_pkg::RT_DONE;
			end
			edm_pkg::RT_DONE: begin
				rt_d = edm_pkg::RT_IDLE;
			end
			default: rt_d = edm_pkg::RT_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_q   <= edm_pkg::RT_IDLE;
			step_q <= '0;
		end else begin
			rt_q <= rt_d;
			if (rt_q == edm_pkg::RT_IDLE)
				step_q <= edm_pkg::STEP_W'(edm_pkg::M_W - 1);
			else if (rt_q == edm_pkg::RT_SQR && step_q == '0)
				step_q <= edm_pkg::STEP_W'(edm_pkg::DIST_W - 1);
			else if (step_q != '0)
				step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (rt_q)
			edm_pkg::RT_IDLE: begin
				if (start) begin
					a0_q  <= a0;
					a1_q  <= a1;
					m_q   <= m;
					sh0_q <= edm_pkg::M_W'(a0);
					sh1_q <= edm_pkg::M_W'(a1);
					shm_q <= m;
					s_q   <= '0;
					msq_q <= '0;
				end
			end
			edm_pkg::RT_SQR: begin
				s_q   <= s_next;
				msq_q <= msq_next;
				sh0_q <= sh0_q << 1;
				sh1_q <= sh1_q << 1;
				shm_q <= shm_q << 1;
				p_q   <= '0;
				ts_q  <= '0;
				ss_q  <= edm_pkg::SQ_W'(s_next) << (2 * (edm_pkg::DIST_W - 1));
			end
			edm_pkg::RT_ROOT: begin
				if (take) p_q <= cand;
				ts_q <= (ts_q >> 1) + (take ? ss_q : '0);
				ss_q <= ss_q >> 2;
				q_q  <= {q_q[edm_pkg::DIST_W-2:0], take};
			end
			edm_pkg::RT_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign done = (rt_q == edm_pkg::RT_DONE);
	assign q    = q_q;

endmodule

### src/epipolar_distance_mean_top.sv
// ----------------------------------------------------------------------------
// epipolar_distance_mean_top: mean point-to-epiline distance
// Bit-serial evaluation of F * [xl yl 1], the right point's distance to
// that line, and a running mean over a set of corner pairs.
// ----------------------------------------------------------------------------
// Usage
//   Input beat: one matched corner pair (left_x/left_y/right_x/right_y in
//   Q12.4) plus last_point. in_stall is high while a pair is in work; the
//   block holds one pair at a time.
//   Output beat: one per input beat, in order: point_distance (Q12.8,
//   saturating), point_counted, set_done, point_count, and on the last
//   pair of a set mean_error (floor(sum/count), 0 if nothing counted).
//   The set's sum and count clear after the last pair's beat is formed.
//   Config: cfg_we/cfg_index/cfg_wdata writes one F register per cycle;
//   write only while idle. Indexes past the corner register are ignored.
// Timing
//   The next pair is taken only after the current pair's result beat is
//   formed. Epiline normalization adds halving steps (0..18 at default
//   widths), and a last pair with a nonzero count adds the serial mean
//   division. A degenerate epiline skips dot product and root. Most of
//   the time per pair goes to the shift-add squarer and the
//   one-bit-per-cycle root search in edm_root.
// Reset: clears F, the set's sum and count, and the output valid.
// Output stall: a finished beat sits in the output register; the next
//   pair is taken meanwhile and waits at its end until the register frees.
// ----------------------------------------------------------------------------
module epipolar_distance_mean_top #(
	parameter int COORD_WIDTH = edm_pkg::DEF_COORD_W,
	parameter int COEF_WIDTH  = edm_pkg::DEF_COEF_W,
	parameter int COUNT_WIDTH = edm_pkg::DEF_COUNT_W
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// config
	input  logic                            cfg_we,
	input  logic [edm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [edm_pkg::CFG_W-1:0]       cfg_wdata,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [COORD_WIDTH-1:0]          left_x,
	input  logic [COORD_WIDTH-1:0]          left_y,
	input  logic [COORD_WIDTH-1:0]          right_x,
	input  logic [COORD_WIDTH-1:0]          right_y,
	input  logic                            last_point,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [edm_pkg::DIST_W-1:0]      point_distance,
	output logic                            point_counted,
	output logic                            set_done,
	output logic [edm_pkg::DIST_W-1:0]      mean_error,
	output logic [COUNT_WIDTH-1:0]          point_count
);

	// epiline width, dot product width, capped magnitude width
	localparam int LW = COEF_WIDTH + COORD_WIDTH + 2;
	localparam int NW = (COEF_WIDTH + COORD_WIDTH + 6 > COORD_WIDTH + 34) ?
		COEF_WIDTH + COORD_WIDTH + 6 : COORD_WIDTH + 34;
	localparam int XW = (NW > edm_pkg::CAP_LOG + 1) ? NW : edm_pkg::CAP_LOG + 1;

	function automatic logic signed [LW-1:0] sx_coef(input logic [31:0] w);
		sx_coef = LW'(signed'(w[COEF_WIDTH-1:0]));
	endfunction

	// unshifted |v| >= 2^(31+s): epiline still needs a halving step.
	// A floored negative value lands on -2^31 with bits dropped when the
	// truncated magnitude is already below 2^31.
	function automatic logic too_big(input logic signed [LW-1:0] v, input logic lost);
		logic signed [63:0] e;
		e = 64'(v);
		too_big = (e > 64'sd2147483647) || (e < -64'sd2147483648)
			|| ((e == -64'sd2147483648) && !lost);
	endfunction

	edm_pkg::state_t state_q, state_d;

	logic [edm_pkg::CFG_W-1:0] fpa_q, fpb_q, fpc_q, fpd_q;
	logic [31:0]               fcn_q;
	logic [edm_pkg::STEP_W-1:0] step_q;

	logic [COORD_WIDTH-1:0] xl_q, yl_q, xr_q, yr_q;
	logic                   last_q, nondeg_q, counted_q;
	logic                   lost0_q, lost1_q;
	logic signed [LW-1:0]   l0_q, l1_q, l2_q;
	logic signed [NW-1:0]   n_q;
	logic [edm_pkg::DIST_W-1:0] dist_q;
	logic [edm_pkg::SUM_W-1:0]  sum_q;
	logic [COUNT_WIDTH-1:0]     cnt_q;
	logic [COUNT_WIDTH:0]       rem_q;
	logic                       out_valid_q;

	logic signed [LW-1:0] c00, c01, c02, c10, c11, c12, c20, c21, c22;
	logic                 big, degen, out_free, out_load, root_start, root_done;
	logic                 count_it;
	logic [COUNT_WIDTH-1:0] cnt_new;
	logic [edm_pkg::SUM_W:0] sum_ext;
	logic [NW-1:0]        n_abs;
	logic [XW-1:0]        n_cap;
	logic [edm_pkg::M_W-1:0] m_val;
	logic [edm_pkg::LMAG_W-1:0] a0_val, a1_val;
	logic [edm_pkg::DIST_W-1:0] root_q;
	logic [COUNT_WIDTH:0] div_trial;
	logic                 div_ge;

	assign c00 = sx_coef(fpa_q[31:0]);
	assign c01 = sx_coef(fpa_q[63:32]);
	assign c02 = sx_coef(fpb_q[31:0]);
	assign c10 = sx_coef(fpb_q[63:32]);
	assign c11 = sx_coef(fpc_q[31:0]);
	assign c12 = sx_coef(fpc_q[63:32]);
	assign c20 = sx_coef(fpd_q[31:0]);
	assign c21 = sx_coef(fpd_q[63:32]);
	assign c22 = sx_coef(fcn_q);

	always_comb begin
		big   = too_big(l0_q, lost0_q) || too_big(l1_q, lost1_q);
		degen = (l0_q == '0) && (l1_q == '0);
		// cap |N| at 2^58 (saturates above that), then scale by 16 for Q.8
		n_abs = n_q[NW-1] ? (~n_q + 1'b1) : n_q;
		n_cap = (XW'(n_abs) > (XW'(1) << edm_pkg::CAP_LOG)) ?
			(XW'(1) << edm_pkg::CAP_LOG) : XW'(n_abs);
		m_val  = edm_pkg::M_W'(n_cap) << edm_pkg::COORD_FRAC;
		a0_val = edm_pkg::LMAG_W'(l0_q[LW-1] ? -l0_q : l0_q);
		a1_val = edm_pkg::LMAG_W'(l1_q[LW-1] ? -l1_q : l1_q);
		// accumulate: counter full or degenerate line skips the pair
		count_it = nondeg_q && (cnt_q != '1);
		cnt_new  = count_it ? cnt_q + 1'b1 : cnt_q;
		sum_ext  = {1'b0, sum_q} + (edm_pkg::SUM_W + 1)'(dist_q);
		// restoring divide step for the mean
		div_trial = {rem_q[COUNT_WIDTH-1:0], sum_q[edm_pkg::SUM_W-1]};
		div_ge    = (div_trial >= {1'b0, cnt_q});
		out_free  = !out_valid_q || !out_stall;
	end

	// controller
	always_comb begin
		state_d    = state_q;
		root_start = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			edm_pkg::ST_IDLE: begin
				if (in_valid) state_d = edm_pkg::ST_LINE;
			end
			edm_pkg::ST_LINE: begin
				if (step_q == '0) state_d = edm_pkg::ST_NORM;
			end
			edm_pkg::ST_NORM: begin
				if (!big) state_d = degen ? edm_pkg::ST_ACC : edm_pkg::ST_DOT;
			end
			edm_pkg::ST_DOT: begin
				if (step_q == '0) state_d = edm_pkg::ST_LAUNCH;
			end
			edm_pkg::ST_LAUNCH: begin
				root_start = 1'b1;
				state_d    = edm_pkg::ST_WAIT;
			end
			edm_pkg::ST_WAIT: begin
				if (root_done) state_d = edm_pkg::ST_ACC;
			end
			edm_pkg::ST_ACC: begin
				state_d = (last_q && cnt_new != '0) ? edm_pkg::ST_DIV : edm_pkg::ST_OUT;
			end
			edm_pkg::ST_DIV: begin
				if (step_q == '0) state_d = edm_pkg::ST_OUT;
			end
			edm_pkg::ST_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = edm_pkg::ST_IDLE;
				end
			end
			default: state_d = edm_pkg::ST_IDLE;
		endcase
	end

	assign in_stall = (state_q != edm_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= edm_pkg::ST_IDLE;
			step_q      <= '0;
			fpa_q       <= '0;
			fpb_q       <= '0;
			fpc_q       <= '0;
			fpd_q       <= '0;
			fcn_q       <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (edm_pkg::cfg_idx_t'(cfg_index))
					edm_pkg::CFG_PAIR_A: fpa_q <= cfg_wdata;
					edm_pkg::CFG_PAIR_B: fpb_q <= cfg_wdata;
					edm_pkg::CFG_PAIR_C: fpc_q <= cfg_wdata;
					edm_pkg::CFG_PAIR_D: fpd_q <= cfg_wdata;
					edm_pkg::CFG_CORNER: fcn_q <= cfg_wdata[31:0];
					default: ;
				endcase
			end
			// phase step counter
			priority if (state_q == edm_pkg::ST_IDLE)
				step_q <= edm_pkg::STEP_W'(COORD_WIDTH - 1);
			else if (state_q == edm_pkg::ST_NORM)
				step_q <= edm_pkg::STEP_W'(COORD_WIDTH - 1);
			else if (state_q == edm_pkg::ST_ACC)
				step_q <= edm_pkg::STEP_W'(edm_pkg::SUM_W - 1);
			else if (step_q != '0)
				step_q <= step_q - 1'b1;
			// set accumulators
			if (state_q == edm_pkg::ST_ACC) begin
				cnt_q <= cnt_new;
				if (count_it)
					sum_q <= sum_ext[edm_pkg::SUM_W] ? '1 : sum_ext[edm_pkg::SUM_W-1:0];
			end else if (state_q == edm_pkg::ST_DIV) begin
				sum_q <= {sum_q[edm_pkg::SUM_W-2:0], div_ge};
			end else if (out_load && last_q) begin
				sum_q <= '0;
				cnt_q <= '0;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			edm_pkg::ST_IDLE: begin
				if (in_valid) begin
					xl_q    <= left_x;
					yl_q    <= left_y;
					xr_q    <= right_x;
					yr_q    <= right_y;
					last_q  <= last_point;
					l0_q    <= '0;
					l1_q    <= '0;
					l2_q    <= '0;
					lost0_q <= 1'b0;
					lost1_q <= 1'b0;
				end
			end
			edm_pkg::ST_LINE: begin
				// MSB first: l = 2l + F*x_bit + F*y_bit, offset on the final bit
				l0_q <= (l0_q <<< 1) + (xl_q[COORD_WIDTH-1] ? c00 : '0)
					+ (yl_q[COORD_WIDTH-1] ? c01 : '0)
					+ ((step_q == '0) ? (c02 <<< edm_pkg::COORD_FRAC) : '0);
				l1_q <= (l1_q <<< 1) + (xl_q[COORD_WIDTH-1] ? c10 : '0)
					+ (yl_q[COORD_WIDTH-1] ? c11 : '0)
					+ ((step_q == '0) ? (c12 <<< edm_pkg::COORD_FRAC) : '0);
				l2_q <= (l2_q <<< 1) + (xl_q[COORD_WIDTH-1] ? c20 : '0)
					+ (yl_q[COORD_WIDTH-1] ? c21 : '0)
					+ ((step_q == '0) ? (c22 <<< edm_pkg::COORD_FRAC) : '0);
				xl_q <= xl_q << 1;
				yl_q <= yl_q << 1;
			end
			edm_pkg::ST_NORM: begin
				// floor halving until the unshifted |l0|,|l1| fall below 2^(31+s)
				if (big) begin
					l0_q    <= l0_q >>> 1;
					l1_q    <= l1_q >>> 1;
					l2_q    <= l2_q >>> 1;
					lost0_q <= lost0_q | l0_q[0];
					lost1_q <= lost1_q | l1_q[0];
				end else begin
					nondeg_q <= !degen;
					dist_q   <= '0;
					n_q      <= '0;
				end
			end
			edm_pkg::ST_DOT: begin
				n_q <= (n_q <<< 1) + (xr_q[COORD_WIDTH-1] ? NW'(l0_q) : '0)
					+ (yr_q[COORD_WIDTH-1] ? NW'(l1_q) : '0)
					+ ((step_q == '0) ? (NW'(l2_q) <<< edm_pkg::COORD_FRAC) : '0);
				xr_q <= xr_q << 1;
				yr_q <= yr_q << 1;
			end
			edm_pkg::ST_LAUNCH: begin
			end
			edm_pkg::ST_WAIT: begin
				if (root_done) dist_q <= root_q;
			end
			edm_pkg::ST_ACC: begin
				counted_q <= count_it;
				rem_q     <= '0;
			end
			edm_pkg::ST_DIV: begin
				rem_q <= div_ge ? (div_trial - {1'b0, cnt_q}) : div_trial;
			end
			edm_pkg::ST_OUT: begin
				if (out_load) begin
					point_distance <= dist_q;
					point_counted  <= counted_q;
					set_done       <= last_q;
					point_count    <= cnt_q;
					mean_error     <= last_q ? sum_q[edm_pkg::DIST_W-1:0] : '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

	edm_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.a0     (a0_val),
		.a1     (a1_val),
		.m      (m_val),
		.done   (root_done),
		.q      (root_q)
	);

	// a new output beat only comes from the output state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == edm_pkg::ST_OUT)
		else $error("output beat without finished pair");

	// a counted pair always leaves a nonzero count
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && point_counted) |-> (point_count != '0))
		else $error("counted pair with zero count");

	// mean only on the last pair
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !set_done) |-> (mean_error == '0))
		else $error("mean reported off the last pair");

	// set accumulators clear once the last beat is formed
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && last_q) |=> (cnt_q == '0 && sum_q == '0))
		else $error("set not cleared after last pair");

	// root unit finishes only while waited on
	assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> state_q == edm_pkg::ST_WAIT)
		else $error("root result outside wait state");

endmodule
